// ===== rtl/mppt_perturb_observe_top_assert.svh =====
// ----------------------------------------------------------------------------
// mppt perturb-and-observe assertion macros
// property wrappers for the tracker top, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MPPT_PERTURB_OBSERVE_TOP_ASSERT_SVH
`define MPPT_PERTURB_OBSERVE_TOP_ASSERT_SVH

`ifndef SYNTH
`define MPPT_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("same-cycle implication failed");
`define MPPT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle implication failed");
`else
`define MPPT_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define MPPT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/mppt_po_pkg.sv =====
// ----------------------------------------------------------------------------
// mppt_po_pkg
// constants, control word format and microcode program of the tracker
// ----------------------------------------------------------------------------
package mppt_po_pkg;

	localparam int SAMPLES      = 16;
	localparam int SAMPLE_SHIFT = $clog2(SAMPLES);
	localparam int CNT_W        = SAMPLE_SHIFT;
	localparam int VSUM_W       = 16 + SAMPLE_SHIFT;
	localparam int PSUM_W       = 32 + SAMPLE_SHIFT;

	localparam logic [11:0] WIDTH_MAX  = 12'd2800;
	localparam logic [13:0] STEP_LIMIT = 14'd100;
	localparam logic [6:0]  LOG10_NUM  = 7'd77;
	localparam logic [14:0] LOG_BIAS   = 15'd2048;
	localparam logic [29:0] ROUND_HALF = 30'd32768;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_TRACK_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SCALE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_WIDTH     = 3'd4;

	typedef struct packed {
		logic        track_enable;
		logic        fixed_step_mode;
		logic [7:0]  fixed_step;
		logic [7:0]  step_scale;
		logic [11:0] start_width;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_ACC,
		OP_AVG,
		OP_DIFF,
		OP_PICK,
		OP_NORM,
		OP_SWAP,
		OP_LOGDIFF,
		OP_SCALE,
		OP_MUL77,
		OP_RANGE,
		OP_APPLY
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_INPUT,
		C_NOT_WINDOW,
		C_NO_TRACK,
		C_SHORTCUT,
		C_OUT_BUSY
	} cond_t;

	localparam int PC_W = 5;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic [4:0]      shift;
	} ctrl_word_t;

	typedef struct packed {
		logic win_close;
		logic shortcut;
	} dp_status_t;

	localparam logic [PC_W-1:0] S_IDLE    = 5'd0;
	localparam logic [PC_W-1:0] S_MUL     = 5'd1;
	localparam logic [PC_W-1:0] S_ACC     = 5'd2;
	localparam logic [PC_W-1:0] S_AVG     = 5'd3;
	localparam logic [PC_W-1:0] S_DIFF    = 5'd4;
	localparam logic [PC_W-1:0] S_PICK    = 5'd5;
	localparam logic [PC_W-1:0] S_NORM_P  = 5'd6;
	localparam logic [PC_W-1:0] S_SWAP    = 5'd11;
	localparam logic [PC_W-1:0] S_NORM_V  = 5'd12;
	localparam logic [PC_W-1:0] S_LOGDIFF = 5'd17;
	localparam logic [PC_W-1:0] S_SCALE   = 5'd18;
	localparam logic [PC_W-1:0] S_MUL77   = 5'd19;
	localparam logic [PC_W-1:0] S_RANGE   = 5'd20;
	localparam logic [PC_W-1:0] S_APPLY   = 5'd21;
	localparam logic [PC_W-1:0] S_OUT     = 5'd22;
	localparam logic [PC_W-1:0] S_WRAP    = 5'd23;

	// jump to target when the condition holds, else fall through
	function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] addr);
		ctrl_word_t w;
		w = '{OP_NONE, C_ALWAYS, S_IDLE, 5'd0};
		case (addr)
			S_IDLE:           w = '{OP_LOAD,    C_NO_INPUT,   S_IDLE,  5'd0};
			S_MUL:            w = '{OP_MUL,     C_NEXT,       S_IDLE,  5'd0};
			S_ACC:            w = '{OP_ACC,     C_NOT_WINDOW, S_OUT,   5'd0};
			S_AVG:            w = '{OP_AVG,     C_NO_TRACK,   S_OUT,   5'd0};
			S_DIFF:           w = '{OP_DIFF,    C_NEXT,       S_IDLE,  5'd0};
			S_PICK:           w = '{OP_PICK,    C_SHORTCUT,   S_APPLY, 5'd0};
			S_NORM_P:         w = '{OP_NORM,    C_NEXT,       S_IDLE,  5'd16};
			S_NORM_P + 5'd1:  w = '{OP_NORM,    C_NEXT,       S_IDLE,  5'd8};
			S_NORM_P + 5'd2:  w = '{OP_NORM,    C_NEXT,       S_IDLE,  5'd4};
			S_NORM_P + 5'd3:  w = '{OP_NORM,    C_NEXT,       S_IDLE,  5'd2};
			S_NORM_P + 5'd4:  w = '{OP_NORM,    C_NEXT,       S_IDLE,  5'd1};
			S_SWAP:           w = '{OP_SWAP,    C_NEXT,       S_IDLE,  5'd0};
			S_NORM_V:         w = '{OP_NORM,    C_NEXT,       S_IDLE,  5'd16};
			S_NORM_V + 5'd1:  w = '{OP_NORM,    C_NEXT,       S_IDLE,  5'd8};
			S_NORM_V + 5'd2:  w = '{OP_NORM,    C_NEXT,       S_IDLE,  5'd4};
			S_NORM_V + 5'd3:  w = '{OP_NORM,    C_NEXT,       S_IDLE,  5'd2};
			S_NORM_V + 5'd4:  w = '{OP_NORM,    C_NEXT,       S_IDLE,  5'd1};
			S_LOGDIFF:        w = '{OP_LOGDIFF, C_NEXT,       S_IDLE,  5'd0};
			S_SCALE:          w = '{OP_SCALE,   C_NEXT,       S_IDLE,  5'd0};
			S_MUL77:          w = '{OP_MUL77,   C_NEXT,       S_IDLE,  5'd0};
			S_RANGE:          w = '{OP_RANGE,   C_NEXT,       S_IDLE,  5'd0};
			S_APPLY:          w = '{OP_APPLY,   C_NEXT,       S_IDLE,  5'd0};
			S_OUT:            w = '{OP_NONE,    C_OUT_BUSY,   S_OUT,   5'd0};
			S_WRAP:           w = '{OP_NONE,    C_ALWAYS,     S_IDLE,  5'd0};
			default:          w = '{OP_NONE,    C_ALWAYS,     S_IDLE,  5'd0};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/mppt_po_channels.sv =====
// ----------------------------------------------------------------------------
// mppt_po channels
// valid/ready channels for sample beats and pulse width beats
// ----------------------------------------------------------------------------
interface mppt_po_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] in_voltage;
	logic [15:0] in_current;

	modport source (output valid, output in_voltage, output in_current, input ready);
	modport sink   (input valid, input in_voltage, input in_current, output ready);
endinterface

interface mppt_po_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] pulse_width;
	logic        window_done;

	modport source (output valid, output pulse_width, output window_done, input ready);
	modport sink   (input valid, input pulse_width, input window_done, output ready);
endinterface

// ===== rtl/mppt_perturb_observe_top.sv =====
// ----------------------------------------------------------------------------
// mppt_perturb_observe_top: microcoded perturb-and-observe pwm tracker
// one sample in flight: a sample is taken only in the idle state, and the next one
//   waits until the result register has loaded this one's beat, which stalls while
//   the receiver has not taken the previous beat; a window close adds averaging, the
//   width update when tracking is on, and the log step search unless the step is fixed
// reset: arst_n clears sums, count, previous averages, width and sequencer, loads register defaults
// ----------------------------------------------------------------------------
module mppt_perturb_observe_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	mppt_po_in_if.sink                            in_ch,
	mppt_po_out_if.source                         out_ch,
	input  logic                                  cfg_we,
	input  logic [mppt_po_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mppt_po_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import mppt_po_pkg::*;
	`include "mppt_perturb_observe_top_assert.svh"

	cfg_t            cfg_q;
	logic [PC_W-1:0] pc_q;
	ctrl_word_t      cw;
	logic            jump;
	logic            in_fire;
	dp_status_t      status;
	logic [11:0]     dp_width;
	logic            dp_done;
	logic            out_valid_q;
	logic [11:0]     out_width_q;
	logic            out_done_q;
	logic            out_load;

	assign cw          = ucode_rom(pc_q);
	assign in_ch.ready = (pc_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;

	always_comb begin
		case (cw.cond)
			C_NEXT:       jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_NO_INPUT:   jump = !in_ch.valid;
			C_NOT_WINDOW: jump = !status.win_close;
			C_NO_TRACK:   jump = !cfg_q.track_enable;
			C_SHORTCUT:   jump = status.shortcut;
			C_OUT_BUSY:   jump = out_valid_q && !out_ch.ready;
			default:      jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= jump ? cw.target : pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_enable    <= 1'b1;
			cfg_q.fixed_step_mode <= 1'b1;
			cfg_q.fixed_step      <= 8'd10;
			cfg_q.step_scale      <= 8'd10;
			cfg_q.start_width     <= 12'd1500;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRACK_ENABLE:    cfg_q.track_enable    <= cfg_wdata[0];
				REG_FIXED_STEP_MODE: cfg_q.fixed_step_mode <= cfg_wdata[0];
				REG_FIXED_STEP:      cfg_q.fixed_step      <= cfg_wdata[7:0];
				REG_STEP_SCALE:      cfg_q.step_scale      <= cfg_wdata[7:0];
				REG_START_WIDTH:     cfg_q.start_width     <= cfg_wdata[11:0];
				default: begin
				end
			endcase
		end
	end

	mppt_po_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cw          (cw),
		.in_fire     (in_fire),
		.in_voltage  (in_ch.in_voltage),
		.in_current  (in_ch.in_current),
		.cfg         (cfg_q),
		.status      (status),
		.pulse_width (dp_width),
		.window_done (dp_done)
	);

	// result register, free once the previous beat is taken
	assign out_load = (pc_q == S_OUT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_width_q <= dp_width;
			out_done_q  <= dp_done;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.pulse_width = out_width_q;
	assign out_ch.window_done = out_done_q;

	`MPPT_ASSERT_NEXT(a_one_item_in_flight, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	`MPPT_ASSERT_IMPLY(a_width_bound, clk, arst_n, out_ch.valid, out_ch.pulse_width <= WIDTH_MAX)
	`MPPT_ASSERT_IMPLY(a_pc_in_program, clk, arst_n, 1'b1, pc_q <= S_WRAP)

endmodule

// ===== rtl/mppt_po_datapath.sv =====
// ----------------------------------------------------------------------------
// mppt_po_datapath
// accumulators, averaging, mitchell log normalizer and width update, driven
// one control word per cycle by the sequencer
// ----------------------------------------------------------------------------
module mppt_po_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mppt_po_pkg::ctrl_word_t  cw,
	input  logic                     in_fire,
	input  logic [15:0]              in_voltage,
	input  logic [15:0]              in_current,
	input  mppt_po_pkg::cfg_t        cfg,
	output mppt_po_pkg::dp_status_t  status,
	output logic [11:0]              pulse_width,
	output logic                     window_done
);
	import mppt_po_pkg::*;

	// control state
	logic [CNT_W-1:0]  count_q;
	logic [VSUM_W-1:0] vsum_q;
	logic [PSUM_W-1:0] psum_q;
	logic [15:0]       last_v_q;
	logic [31:0]       last_p_q;
	logic [11:0]       width_q;
	logic              started_q;
	logic              done_q;

	// working registers
	logic [15:0] volt_q;
	logic [15:0] curr_q;
	logic [31:0] prod_q;
	logic [15:0] avgv_q;
	logic [31:0] avgp_q;
	logic [32:0] dp_q;
	logic [16:0] dv_q;
	logic [31:0] norm_q;
	logic [4:0]  exp_q;
	logic [12:0] mlp_q;
	logic [13:0] lval_q;
	logic [28:0] mul_q;
	logic [7:0]  step_q;

	logic [32:0] dp_mag;
	logic [16:0] dv_mag;
	logic [12:0] ml_cur;
	logic [5:0]  nsh_rev;
	logic        top_zero;
	logic [14:0] ldiff;
	logic [14:0] lmag;
	logic [21:0] scl_prod;
	logic [35:0] m77;
	logic [29:0] rsum;
	logic [13:0] rstep;
	logic        up;
	logic [13:0] wsum;
	logic [11:0] wclamp;
	logic [11:0] start_clamp;

	assign dp_mag   = dp_q[32] ? (33'd0 - dp_q) : dp_q;
	assign dv_mag   = dv_q[16] ? (17'd0 - dv_q) : dv_q;
	assign ml_cur   = {exp_q, norm_q[30:23]};
	assign nsh_rev  = 6'd32 - {1'b0, cw.shift};
	assign top_zero = (norm_q >> nsh_rev) == 32'd0;
	assign ldiff    = {2'b00, mlp_q} - {2'b00, ml_cur} - LOG_BIAS;
	assign lmag     = ldiff[14] ? (15'd0 - ldiff) : ldiff;
	assign scl_prod = cfg.step_scale * lval_q;
	assign m77      = mul_q * LOG10_NUM;
	assign rsum     = {1'b0, mul_q} + ROUND_HALF;
	assign rstep    = rsum[29:16];

	// width rises when power and voltage moved in opposite directions
	assign up   = dp_q[32] ^ dv_q[16];
	assign wsum = up ? ({2'b00, width_q} + {6'b0, step_q})
	                 : ({2'b00, width_q} - {6'b0, step_q});

	always_comb begin
		if (wsum[13]) begin
			wclamp = 12'd0;
		end else if (wsum[12:0] > {1'b0, WIDTH_MAX}) begin
			wclamp = WIDTH_MAX;
		end else begin
			wclamp = wsum[11:0];
		end
	end

	assign start_clamp = (cfg.start_width > WIDTH_MAX) ? WIDTH_MAX : cfg.start_width;

	assign status.win_close = count_q == CNT_W'(SAMPLES - 1);
	assign status.shortcut  = cfg.fixed_step_mode || (dp_q == 33'd0) || (dv_q == 17'd0);
	assign pulse_width      = width_q;
	assign window_done      = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			vsum_q    <= '0;
			psum_q    <= '0;
			last_v_q  <= '0;
			last_p_q  <= '0;
			width_q   <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			case (cw.op)
				OP_LOAD: begin
					if (in_fire) begin
						done_q <= 1'b0;
						if (!started_q) begin
							width_q   <= start_clamp;
							started_q <= 1'b1;
						end
					end
				end
				OP_ACC: begin
					vsum_q  <= vsum_q + VSUM_W'(volt_q);
					psum_q  <= psum_q + PSUM_W'(prod_q);
					count_q <= count_q + 1'b1;
				end
				OP_AVG: begin
					vsum_q  <= '0;
					psum_q  <= '0;
					count_q <= '0;
					done_q  <= 1'b1;
				end
				OP_APPLY: begin
					width_q  <= wclamp;
					last_p_q <= avgp_q;
					last_v_q <= avgv_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			OP_LOAD: begin
				volt_q <= in_voltage;
				curr_q <= in_current;
			end
			OP_MUL: prod_q <= volt_q * curr_q;
			OP_AVG: begin
				avgv_q <= vsum_q[VSUM_W-1:SAMPLE_SHIFT];
				avgp_q <= psum_q[PSUM_W-1:SAMPLE_SHIFT];
			end
			OP_DIFF: begin
				dp_q <= {1'b0, avgp_q} - {1'b0, last_p_q};
				dv_q <= {1'b0, avgv_q} - {1'b0, last_v_q};
			end
			OP_PICK: begin
				step_q <= cfg.fixed_step_mode ? cfg.fixed_step : cfg.step_scale;
				norm_q <= dp_mag[31:0];
				exp_q  <= 5'd31;
			end
			OP_NORM: begin
				// one stage of the leading-one search
				if (top_zero) begin
					norm_q <= norm_q << cw.shift;
					exp_q  <= exp_q - cw.shift;
				end
			end
			OP_SWAP: begin
				mlp_q  <= ml_cur;
				norm_q <= {16'd0, dv_mag[15:0]};
				exp_q  <= 5'd31;
			end
			OP_LOGDIFF: lval_q <= lmag[13:0];
			OP_SCALE:   mul_q  <= {7'd0, scl_prod};
			OP_MUL77:   mul_q  <= m77[28:0];
			OP_RANGE: begin
				if (rstep == 14'd0 || rstep > STEP_LIMIT) begin
					step_q <= cfg.step_scale;
				end else begin
					step_q <= rstep[7:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
